// ----- src/mte_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mte_pkg;

   // event kinds
   localparam logic [1:0] FUNC_TEMPO    = 2'd0;
   localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
   localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;
   localparam logic [1:0] FUNC_END      = 2'd3;

   // register indexes
   localparam logic [1:0] REG_CHANNEL  = 2'd0;
   localparam logic [1:0] REG_VELOCITY = 2'd1;
   localparam logic [1:0] REG_TEMPO    = 2'd2;

   // reset values of the registers
   localparam logic [3:0]  CHANNEL_RESET  = 4'd0;
   localparam logic [6:0]  VELOCITY_RESET = 7'd64;
   localparam logic [23:0] TEMPO_RESET    = 24'd500000;

   // track bytes
   localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [7:0] STATUS_META     = 8'hFF;
   localparam logic [7:0] META_TEMPO      = 8'h51;
   localparam logic [7:0] META_TEMPO_LEN  = 8'h03;
   localparam logic [7:0] META_END_TRACK  = 8'h2F;
   localparam logic [7:0] BYTE_ZERO       = 8'h00;

   // longest event: five delta bytes plus six tempo bytes
   localparam int MAX_BYTES = 11;
   localparam int CNT_W     = 4;

   typedef logic [7:0] byte_type;
   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic [3:0]  channel;
      logic [6:0]  velocity;
      logic [23:0] tempo;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] delta;
      logic [6:0]  pitch;
   } event_type;

endpackage

`default_nettype wire

// ----- src/mte_intf.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface mte_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] event_tick;
   logic [6:0]  pitch;

   modport source (output valid, func, event_tick, pitch, input ready);
   modport sink   (input valid, func, event_tick, pitch, output ready);
endinterface

interface mte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface mte_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/midi_track_event_encoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// MIDI track event encoder: takes tempo, note on, note off and end of track
// requests in tick order and streams the track bytes, one byte per cycle while
// the receiver is ready, with last_byte on the final byte of each event. Each
// event opens with its tick delta (modulo 2^32, 1 to 5 bytes of variable-length
// quantity); end of track is always 00 FF 2F 00 and leaves the stored tick
// alone. An event has 4 to 11 bytes (tempo 7-11, notes 4-8, end of track 4),
// sent from the output shift register. When the output is free, the first
// byte of a request shows once it has passed the request register and then
// the output shift register, and a request is taken while the previous event
// is still being sent, so the output runs without gaps as long as requests
// keep up. Registers are written through the csr channel, always ready; the
// user must write them only while the block is idle; the block does not check.

module midi_track_event_encoder (
   input wire logic clock,
   input wire logic reset,
   mte_req_if.sink  req_chan,
   mte_rsp_if.source rsp_chan,
   mte_csr_if.sink  csr_chan
);
   import mte_pkg::*;

   // configuration registers
   cfg_type     cfg_ff, cfg_in;

   // tick of the last timed event
   logic [31:0] prev_tick_ff, prev_tick_in;

   // request register: event with its delta already taken
   logic        in_valid_ff, in_valid_in;
   event_type   in_evt_ff, in_evt_in;

   // output shift register and bytes left to send
   byte_type    buf_ff [MAX_BYTES];
   byte_type    buf_in [MAX_BYTES];
   count_type   rem_ff, rem_in;

   byte_type    enc_bytes [MAX_BYTES];
   count_type   enc_count;

   logic        req_fire;
   logic        rsp_fire;
   logic        load;

   mte_encode u_encode (
      .evt   (in_evt_ff),
      .cfg   (cfg_ff),
      .bytes (enc_bytes),
      .count (enc_count)
   );

   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid     = (rem_ff != '0);
   assign rsp_chan.data_byte = buf_ff[0];
   assign rsp_chan.last_byte = (rem_ff == CNT_W'(1));
   assign rsp_fire           = rsp_chan.valid && rsp_chan.ready;

   // next event moves into the shift register when it is empty or its
   // last byte leaves this cycle
   assign load = in_valid_ff && ((rem_ff == '0) || rsp_fire && rsp_chan.last_byte);

   assign req_chan.ready = !in_valid_ff || load;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // register writes, masked to each register's width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_CHANNEL:  cfg_in.channel  = csr_chan.data[3:0];
            REG_VELOCITY: cfg_in.velocity = csr_chan.data[6:0];
            REG_TEMPO:    cfg_in.tempo    = csr_chan.data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // request capture and tick delta
   always_comb begin
      in_evt_in    = in_evt_ff;
      prev_tick_in = prev_tick_ff;
      in_valid_in  = in_valid_ff;
      if (load) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in     = 1'b1;
         in_evt_in.func  = req_chan.func;
         in_evt_in.delta = req_chan.event_tick - prev_tick_ff;
         in_evt_in.pitch = req_chan.pitch;
         if (req_chan.func != FUNC_END) begin
            prev_tick_in = req_chan.event_tick;
         end
      end
   end

   // output shift register
   always_comb begin
      buf_in = buf_ff;
      rem_in = rem_ff;
      if (load) begin
         buf_in = enc_bytes;
         rem_in = enc_count;
      end else if (rsp_fire) begin
         for (int i = 0; i < MAX_BYTES - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         buf_in[MAX_BYTES-1] = BYTE_ZERO;
         rem_in = rem_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel  <= CHANNEL_RESET;
         cfg_ff.velocity <= VELOCITY_RESET;
         cfg_ff.tempo    <= TEMPO_RESET;
         prev_tick_ff    <= '0;
         in_valid_ff     <= 1'b0;
         rem_ff          <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         prev_tick_ff <= prev_tick_in;
         in_valid_ff  <= in_valid_in;
         rem_ff       <= rem_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_evt_ff <= in_evt_in;
      buf_ff    <= buf_in;
   end

endmodule

`default_nettype wire

// ----- src/mte_encode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mte_encode (
   input  wire mte_pkg::event_type evt,
   input  wire mte_pkg::cfg_type   cfg,
   output mte_pkg::byte_type  bytes [mte_pkg::MAX_BYTES],
   output mte_pkg::count_type count
);
   import mte_pkg::*;

   byte_type   grp [8];
   byte_type   tail [8];
   logic [2:0] vlq_len;
   logic [2:0] tail_len;
   count_type  pos;
   logic [2:0] gsel;
   logic [2:0] tsel;

   always_comb begin
      // delta groups, least significant first, continuation bit on upper groups
      grp[0] = {1'b0, evt.delta[6:0]};
      grp[1] = {1'b1, evt.delta[13:7]};
      grp[2] = {1'b1, evt.delta[20:14]};
      grp[3] = {1'b1, evt.delta[27:21]};
      grp[4] = {1'b1, 3'b000, evt.delta[31:28]};
      grp[5] = BYTE_ZERO;
      grp[6] = BYTE_ZERO;
      grp[7] = BYTE_ZERO;

      if (evt.delta[31:28] != 4'd0)      vlq_len = 3'd5;
      else if (evt.delta[27:21] != 7'd0) vlq_len = 3'd4;
      else if (evt.delta[20:14] != 7'd0) vlq_len = 3'd3;
      else if (evt.delta[13:7] != 7'd0)  vlq_len = 3'd2;
      else                               vlq_len = 3'd1;

      for (int j = 0; j < 8; j++) begin
         tail[j] = BYTE_ZERO;
      end

      case (evt.func)
         FUNC_TEMPO: begin
            tail[0]  = STATUS_META;
            tail[1]  = META_TEMPO;
            tail[2]  = META_TEMPO_LEN;
            tail[3]  = cfg.tempo[23:16];
            tail[4]  = cfg.tempo[15:8];
            tail[5]  = cfg.tempo[7:0];
            tail_len = 3'd6;
         end
         FUNC_NOTE_ON: begin
            tail[0]  = STATUS_NOTE_ON | {4'd0, cfg.channel};
            tail[1]  = {1'b0, evt.pitch};
            tail[2]  = {1'b0, cfg.velocity};
            tail_len = 3'd3;
         end
         default: begin
            tail[0]  = STATUS_NOTE_OFF | {4'd0, cfg.channel};
            tail[1]  = {1'b0, evt.pitch};
            tail[2]  = BYTE_ZERO;
            tail_len = 3'd3;
         end
      endcase

      for (int i = 0; i < MAX_BYTES; i++) begin
         pos  = CNT_W'(i);
         gsel = 3'(vlq_len - 3'd1 - pos[2:0]);
         tsel = 3'(pos - {1'b0, vlq_len});
         if (pos < {1'b0, vlq_len}) begin
            bytes[i] = grp[gsel];
         end else begin
            bytes[i] = tail[tsel];
         end
      end
      count = {1'b0, vlq_len} + {1'b0, tail_len};

      // end of track is a fixed sequence with a zero delta
      if (evt.func == FUNC_END) begin
         bytes[0] = BYTE_ZERO;
         bytes[1] = STATUS_META;
         bytes[2] = META_END_TRACK;
         bytes[3] = BYTE_ZERO;
         count    = CNT_W'(4);
      end
   end

endmodule

`default_nettype wire

// ----- src/mte_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mte_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_data_byte,
   input wire logic       rsp_last_byte
);

   logic       req_fire;
   logic       rsp_fire;
   logic [3:0] run_ff, run_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // bytes sent since the last end of event
   always_comb begin
      run_in = run_ff;
      if (rsp_fire) begin
         run_in = rsp_last_byte ? 4'd0 : run_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 4'd0;
      end else begin
         run_ff <= run_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data_byte) && $stable(rsp_last_byte))
      else $error("stalled response changed");

   a_start_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_fire, 2))
      else $error("output started without a request two cycles before");

   a_event_length: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last_byte |-> run_ff <= 4'd9)
      else $error("event longer than eleven bytes");

endmodule

bind midi_track_event_encoder mte_checker u_mte_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_data_byte (rsp_chan.data_byte),
   .rsp_last_byte (rsp_chan.last_byte)
);

`default_nettype wire
